// ----- design/md5_stream_hasher_assert.svh -----
// ----------------------------------------------------------------------------
// md5_stream_hasher assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MD5_STREAM_HASHER_ASSERT_SVH
`define MD5_STREAM_HASHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define MD5SH_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("md5_stream_hasher: same-cycle check failed");

// Next-cycle implication
`define MD5SH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("md5_stream_hasher: next-cycle check failed");

`else

`define MD5SH_ASSERT_IMPL(label, ante, cons)
`define MD5SH_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/md5sh_pkg.sv -----
// ----------------------------------------------------------------------------
// md5sh_pkg
// Types, initial chaining values, round constants and round schedule
// helpers shared by the MD5 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package md5sh_pkg;

	// Four 32-bit chaining or working words
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} words_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE     = 8'h80;
	localparam logic [5:0] LEN_LIMIT    = 6'd56;
	localparam logic [3:0] LEN_WORD_LO  = 4'd14;
	localparam logic [3:0] LEN_WORD_HI  = 4'd15;
	localparam logic [3:0] LAST_WORD    = 4'd15;
	localparam logic [5:0] LAST_ROUND   = 6'd63;
	localparam logic [1:0] LAST_DIGEST  = 2'd3;

	// Round groups
	localparam logic [1:0] GRP_F = 2'd0;
	localparam logic [1:0] GRP_G = 2'd1;
	localparam logic [1:0] GRP_H = 2'd2;
	localparam logic [1:0] GRP_I = 2'd3;

	localparam logic [31:0] K_TABLE [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// Left-rotate amount of a round: four per group
	function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
		unique case ({rnd[5:4], rnd[1:0]})
			4'd0:  return 5'd7;
			4'd1:  return 5'd12;
			4'd2:  return 5'd17;
			4'd3:  return 5'd22;
			4'd4:  return 5'd5;
			4'd5:  return 5'd9;
			4'd6:  return 5'd14;
			4'd7:  return 5'd20;
			4'd8:  return 5'd4;
			4'd9:  return 5'd11;
			4'd10: return 5'd16;
			4'd11: return 5'd23;
			4'd12: return 5'd6;
			4'd13: return 5'd10;
			4'd14: return 5'd15;
			default: return 5'd21;
		endcase
	endfunction

	// Message word used by a round
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] lo;
		lo = rnd[3:0];
		unique case (rnd[5:4])
			GRP_F: return lo;
			GRP_G: return 4'(lo * 4'd5 + 4'd1);
			GRP_H: return 4'(lo * 4'd3 + 4'd5);
			default: return 4'(lo * 4'd7);
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- design/md5sh_ram.sv -----
// ----------------------------------------------------------------------------
// md5sh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module md5sh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- design/md5sh_round.sv -----
// ----------------------------------------------------------------------------
// md5sh_round
// One MD5 round step: round function, four-way add, rotate and add of b.
// ----------------------------------------------------------------------------
`default_nettype none

module md5sh_round (
	input  wire md5sh_pkg::words_t cur,
	input  wire logic [31:0]       msg_word,
	input  wire logic [5:0]        rnd,
	output logic      [31:0]       new_b
);

	import md5sh_pkg::*;

	logic [31:0] f;
	logic [31:0] t;
	logic [4:0]  s;
	logic [63:0] rot;

	// Select the round function of the group
	always_comb begin
		unique case (rnd[5:4])
			GRP_F: f = cur.d ^ (cur.b & (cur.c ^ cur.d));
			GRP_G: f = cur.c ^ (cur.d & (cur.b ^ cur.c));
			GRP_H: f = cur.b ^ cur.c ^ cur.d;
			GRP_I: f = cur.c ^ (cur.b | ~cur.d);
		endcase
	end

	// Add, rotate left, add b
	always_comb begin
		t     = cur.a + f + msg_word + K_TABLE[rnd];
		s     = rot_amount(rnd);
		rot   = {t, t} << s;
		new_b = cur.b + rot[63:32];
	end

endmodule

`default_nettype wire

// ----- design/md5_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// md5_stream_hasher: byte-serial MD5; byte items are taken while idle, and the
// 64th byte of a block starts its compression (load, 64 rounds on one round unit, sum).
// End item: each final block (two at most) is padded and compressed, then
// four digest items, one per cycle when not stalled. Reset: IV, count 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "md5_stream_hasher_assert.svh"

module md5_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] digest_word,
	output logic      [1:0]  word_index,
	output logic             last_word
);

	import md5sh_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_FINISH,
		ST_OUT
	} state_t;

	state_t      state_q;
	words_t      chain_q;
	words_t      work_q;
	words_t      chain_sum;
	logic [60:0] count_q;
	logic [60:0] count_nx;
	logic [60:0] count_after;
	logic [63:0] bit_len;
	logic [5:0]  rnd_q;
	logic [3:0]  pad_idx_q;
	logic        final_q;
	logic        pad1_done_q;
	logic        second_q;
	logic [1:0]  out_idx_q;
	logic [1:0]  out_idx_nx;
	logic        out_valid_q;
	logic [31:0] digest_q;
	logic        last_q;
	logic [31:0] asm_q;

	logic        accept_in;
	logic        take_byte;
	logic        block_full;
	logic        len_here;
	logic [31:0] pad_word;
	logic [31:0] new_b;

	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [31:0] wr_data;
	logic [3:0]  rd_addr;
	logic [31:0] rd_data;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept_in   = in_valid && !in_stall;
	assign take_byte   = accept_in && byte_present;
	assign count_nx    = count_q + 61'd1;
	assign count_after = byte_present ? count_nx : count_q;
	assign block_full  = take_byte && (count_q[5:0] == 6'd63);
	assign bit_len     = {count_q, 3'b000};
	assign len_here    = second_q || (count_q[5:0] < LEN_LIMIT);
	assign out_idx_nx  = out_idx_q + 2'd1;

	assign out_valid   = out_valid_q;
	assign digest_word = digest_q;
	assign word_index  = out_idx_q;
	assign last_word   = last_q;

	// Build the pad word: partial bytes plus 0x80, zero fill or bit length
	always_comb begin
		pad_word = '0;
		if (!second_q && (pad_idx_q == count_q[5:2])) begin
			for (int lane = 0; lane < 4; lane++) begin
				if (2'(lane) < count_q[1:0]) begin
					pad_word[8*lane +: 8] = asm_q[8*lane +: 8];
				end else if (2'(lane) == count_q[1:0]) begin
					pad_word[8*lane +: 8] = PAD_BYTE;
				end
			end
		end else if (len_here && (pad_idx_q == LEN_WORD_LO)) begin
			pad_word = bit_len[31:0];
		end else if (len_here && (pad_idx_q == LEN_WORD_HI)) begin
			pad_word = bit_len[63:32];
		end
	end

	// Steer the block store write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[5:2];
		wr_data = {data_byte, asm_q[23:0]};
		if (state_q == ST_PAD) begin
			wr_en   = 1'b1;
			wr_addr = pad_idx_q;
			wr_data = pad_word;
		end else if (take_byte && (count_q[1:0] == 2'd3)) begin
			wr_en = 1'b1;
		end
	end

	// Fetch the message word in the cycle before its round
	assign rd_addr = (state_q == ST_LOAD) ? msg_index('0) : msg_index(rnd_q + 6'd1);

	md5sh_ram #(
		.WIDTH(32),
		.DEPTH(16)
	) u_block_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	md5sh_round u_round (
		.cur     (work_q),
		.msg_word(rd_data),
		.rnd     (rnd_q),
		.new_b   (new_b)
	);

	// Feed-forward add of the compressed block
	always_comb begin
		chain_sum.a = chain_q.a + work_q.a;
		chain_sum.b = chain_q.b + work_q.b;
		chain_sum.c = chain_q.c + work_q.c;
		chain_sum.d = chain_q.d + work_q.d;
	end

	// Collect bytes into the current word
	always_ff @(posedge clk) begin
		if (take_byte) begin
			asm_q[8*count_q[1:0] +: 8] <= data_byte;
		end
	end

	// Load and advance the working words
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			work_q <= chain_q;
		end else if (state_q == ST_ROUND) begin
			work_q.a <= work_q.d;
			work_q.b <= new_b;
			work_q.c <= work_q.b;
			work_q.d <= work_q.c;
		end
	end

	// Sequencer, chaining state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chain_q.a   <= IV_A;
			chain_q.b   <= IV_B;
			chain_q.c   <= IV_C;
			chain_q.d   <= IV_D;
			count_q     <= '0;
			rnd_q       <= '0;
			pad_idx_q   <= '0;
			final_q     <= 1'b0;
			pad1_done_q <= 1'b0;
			second_q    <= 1'b0;
			out_idx_q   <= '0;
			out_valid_q <= 1'b0;
			digest_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						count_q     <= count_after;
						final_q     <= end_of_message;
						pad1_done_q <= 1'b0;
						second_q    <= 1'b0;
						pad_idx_q   <= count_after[5:2];
						if (block_full) begin
							state_q <= ST_LOAD;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_idx_q <= pad_idx_q + 4'd1;
					if (pad_idx_q == LAST_WORD) begin
						pad1_done_q <= 1'b1;
						state_q     <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					chain_q <= chain_sum;
					if (!final_q) begin
						state_q <= ST_IDLE;
					end else if (!pad1_done_q) begin
						pad_idx_q <= count_q[5:2];
						state_q   <= ST_PAD;
					end else if (!second_q && (count_q[5:0] >= LEN_LIMIT)) begin
						second_q  <= 1'b1;
						pad_idx_q <= '0;
						state_q   <= ST_PAD;
					end else begin
						out_idx_q   <= '0;
						out_valid_q <= 1'b1;
						digest_q    <= chain_sum.a;
						last_q      <= 1'b0;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (out_idx_q == LAST_DIGEST) begin
							out_valid_q <= 1'b0;
							last_q      <= 1'b0;
							chain_q.a   <= IV_A;
							chain_q.b   <= IV_B;
							chain_q.c   <= IV_C;
							chain_q.d   <= IV_D;
							count_q     <= '0;
							final_q     <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							out_idx_q <= out_idx_nx;
							last_q    <= (out_idx_nx == LAST_DIGEST);
							unique case (out_idx_nx)
								2'd1: digest_q <= chain_q.b;
								2'd2: digest_q <= chain_q.c;
								2'd3: digest_q <= chain_q.d;
								default: digest_q <= chain_q.a;
							endcase
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks
	`MD5SH_ASSERT_IMPL(a_no_take_while_out, out_valid, in_stall)
	`MD5SH_ASSERT_NEXT(a_last_drains, out_valid && !out_stall && last_word, !out_valid && !in_stall)
	`MD5SH_ASSERT_NEXT(a_round_end, (state_q == ST_ROUND) && (rnd_q == LAST_ROUND), state_q == ST_FINISH)
	`MD5SH_ASSERT_NEXT(a_word_step, out_valid && !out_stall && !last_word, out_valid && (word_index == $past(word_index) + 2'd1))

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher testbench
// Streams byte-serial messages into the hasher and predicts every digest
// with an independent MD5 model. Runs directed short messages, then random
// messages weighted toward the padding boundaries, with random idling on
// both channels and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------

module testbench;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  pos;
		logic        last;
	} digest_word_t;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_MARK = 8'h80;
	localparam logic [1:0]  FINAL_POS = 2'd3;

	localparam logic [31:0] SINE_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_AMT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 1500;
	localparam int HOLD_AT_WORD = 12;
	localparam int CALM_ITEMS   = 40;
	localparam int DRAIN_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	// stimulus and prediction state
	msg_item_t    message_items [$];
	digest_word_t pending_digest [$];
	msg_item_t    in_flight;
	logic [31:0]  hash_a = INIT_A, hash_b = INIT_B, hash_c = INIT_C, hash_d = INIT_D;
	logic [7:0]   msg_block [64];
	logic [60:0]  msg_len = '0;
	int           items_planned = 0;
	int           messages_planned = 0;
	int           total_words = 0;
	int           items_taken = 0;
	int           words_seen = 0;
	int           mismatches = 0;
	int           send_gap = 0;
	int           send_idle_pct = 0;
	int           hold_left = 0;
	int           recv_idle_pct = 0;
	int           recv_cycles = 0;
	int           cycle_count = 0;

	md5_stream_hasher uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.byte_present  (byte_present),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.digest_word   (digest_word),
		.word_index    (word_index),
		.last_word     (last_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run the 64 MD5 rounds over the collected block and fold into the chain
	function automatic void md5_compress();
		logic [31:0] m [16];
		logic [31:0] a, b, c, d, f, t;
		int          r, g, s, i;
		for (i = 0; i < 16; i++) begin
			m[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
		end
		a = hash_a;
		b = hash_b;
		c = hash_c;
		d = hash_d;
		for (r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			t = a + f + m[g] + SINE_K[r];
			s = ROT_AMT[(r / 16) * 4 + (r % 4)];
			a = d;
			d = c;
			c = b;
			b = b + ((t << s) | (t >> (32 - s)));
		end
		hash_a = hash_a + a;
		hash_b = hash_b + b;
		hash_c = hash_c + c;
		hash_d = hash_d + d;
	endfunction

	// Absorb one accepted item; on end of message pad, finish and queue the digest
	function automatic void absorb_item(input msg_item_t it);
		logic [63:0]  bit_len;
		logic [31:0]  words [4];
		digest_word_t dw;
		int           used, k;
		if (it.has_byte) begin
			msg_block[msg_len[5:0]] = it.data;
			msg_len = msg_len + 61'd1;
			if (msg_len[5:0] == 6'd0)
				md5_compress();
		end
		if (!it.eom)
			return;
		used = msg_len[5:0];
		msg_block[used] = PAD_MARK;
		used = used + 1;
		// no room for the length: flush an extra block
		if (used > 56) begin
			while (used < 64) begin
				msg_block[used] = 8'h00;
				used = used + 1;
			end
			md5_compress();
			used = 0;
		end
		while (used < 56) begin
			msg_block[used] = 8'h00;
			used = used + 1;
		end
		bit_len = {msg_len, 3'b000};
		for (k = 0; k < 8; k++)
			msg_block[56 + k] = bit_len[8*k +: 8];
		md5_compress();
		words[0] = hash_a;
		words[1] = hash_b;
		words[2] = hash_c;
		words[3] = hash_d;
		for (k = 0; k < 4; k++) begin
			dw.word = words[k];
			dw.pos  = 2'(k);
			dw.last = (2'(k) == FINAL_POS);
			pending_digest.push_back(dw);
		end
		hash_a  = INIT_A;
		hash_b  = INIT_B;
		hash_c  = INIT_C;
		hash_d  = INIT_D;
		msg_len = '0;
	endfunction

	task automatic push_item(input logic [7:0] data, input logic has_byte, input logic eom);
		msg_item_t it;
		it.data     = data;
		it.has_byte = has_byte;
		it.eom      = eom;
		message_items.push_back(it);
		if (has_byte || eom)
			items_planned++;
		if (eom) begin
			messages_planned++;
			total_words += 4;
		end
	endtask

	// Queue one message of random bytes, sprinkled with empty items
	task automatic add_message(input int len, input bit byte_ends);
		int k;
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 11) == 0)
				push_item(8'($urandom), 1'b0, 1'b0);
			push_item(8'($urandom), 1'b1, byte_ends && (k == len - 1));
		end
		if (!byte_ends || len == 0)
			push_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Drive input items from the queue, with bursts of idle cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid       <= 1'b0;
			data_byte      <= 8'h00;
			byte_present   <= 1'b0;
			end_of_message <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				absorb_item(in_flight);
				items_taken++;
				if (items_taken % 48 == 0)
					case ($urandom_range(0, 2))
						0: send_idle_pct = 0;
						1: send_idle_pct = 10;
						default: send_idle_pct = 35;
					endcase
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (message_items.size() > CALM_ITEMS &&
					$urandom_range(0, 99) < send_idle_pct) begin
					send_gap = $urandom_range(0, 12);
					in_valid <= 1'b0;
				end else if (message_items.size() > 0) begin
					in_flight = message_items.pop_front();
					data_byte      <= in_flight.data;
					byte_present   <= in_flight.has_byte;
					end_of_message <= in_flight.eom;
					in_valid       <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check digest words and drive the output stall
	always @(posedge clk or negedge arst_n) begin
		digest_word_t due;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_digest.size() == 0) begin
					$display("%0t: digest word with none expected: actual %h index %0d last %b",
						$time, digest_word, word_index, last_word);
					mismatches++;
				end else begin
					due = pending_digest.pop_front();
					if (digest_word !== due.word) begin
						$display("%0t: digest_word: expected %h, actual %h",
							$time, due.word, digest_word);
						mismatches++;
					end
					if (word_index !== due.pos) begin
						$display("%0t: word_index: expected %0d, actual %0d",
							$time, due.pos, word_index);
						mismatches++;
					end
					if (last_word !== due.last) begin
						$display("%0t: last_word: expected %b, actual %b",
							$time, due.last, last_word);
						mismatches++;
					end
				end
				words_seen++;
				// hold off long enough for the input side to back up
				if (words_seen == HOLD_AT_WORD)
					hold_left = HOLD_CYCLES;
			end
			recv_cycles++;
			if (recv_cycles % 64 == 0)
				case ($urandom_range(0, 2))
					0: recv_idle_pct = 0;
					1: recv_idle_pct = 15;
					default: recv_idle_pct = 40;
				endcase
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (words_seen + 16 < total_words &&
				$urandom_range(0, 99) < recv_idle_pct) begin
				out_stall <= 1'b1;
				hold_left = $urandom_range(0, 12);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("md5_stream_hasher regression: fail");
			$finish;
		end
	end

	initial begin
		int boundary_len [12];
		int len, sel;
		boundary_len = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};

		// directed: empty items, empty message, byte extremes, a short text
		push_item(8'hff, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
		push_item(8'h00, 1'b1, 1'b1);
		push_item(8'hff, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'hff, 1'b0, 1'b1);
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'h63, 1'b1, 1'b1);
		push_item(8'h5a, 1'b0, 1'b1);

		// padding boundaries: pad fits, pad spills into an extra block, full block
		add_message(55, 1'b1);
		add_message(56, 1'b0);
		add_message(63, 1'b0);
		add_message(64, 1'b1);

		// random messages: short, at the block and length boundaries, longer, or empty
		while (items_planned < 360 || messages_planned < 16) begin
			sel = $urandom_range(0, 9);
			if (sel < 4)
				len = $urandom_range(0, 12);
			else if (sel < 8)
				len = boundary_len[$urandom_range(0, 11)];
			else if (sel == 8)
				len = $urandom_range(13, 140);
			else
				len = 0;
			add_message(len, $urandom_range(0, 1));
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (message_items.size() != 0 || in_valid)
			@(negedge clk);
		while (pending_digest.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("md5_stream_hasher regression: pass");
		else
			$display("md5_stream_hasher regression: fail");
		$finish;
	end

endmodule

// ----- md5_stream_hasher.f -----
+incdir+design
design/md5sh_pkg.sv
design/md5sh_ram.sv
design/md5sh_round.sv
design/md5_stream_hasher.sv
bench/testbench.sv
